// File: hdl/chacha8_stream_cipher_unit_defines.svh
// Assertion macros shared by the cipher RTL.
// Plain SystemVerilog, no dependencies.
`ifndef CHACHA8_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA8_STREAM_CIPHER_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define CC8_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define CC8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cc8_pkg.sv
// Shared types and constants for the ChaCha8 byte cipher.
// No dependencies.
package cc8_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int ROUND_TOTAL = ((ROUND_COUNT + 1) / 2) * 2;
    localparam int STEP_TOTAL  = ROUND_TOTAL * 4;
    localparam int STEP_W      = $clog2(STEP_TOTAL);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_REGS   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE  = 3'd4;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic start;
    } cc8_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cc8_stat_t;

endpackage

// File: hdl/cc8_if.sv
// Valid/ready channel interfaces for message bytes in and out.
// No dependencies.
interface cc8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       result_last;

    modport source (output valid, output result_byte, output result_last, input ready);
    modport sink   (input valid, input result_byte, input result_last, output ready);
endinterface

// File: hdl/cc8_core.sv
// ChaCha block core: one add/xor/rotate step on four lanes per cycle.
// Depends on cc8_pkg.
module cc8_core
    import cc8_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cc8_ctl_t        ctl,
    output cc8_stat_t       stat,
    input  cfg_word_t       key_words [KEY_REGS],
    input  cfg_word_t       nonce,
    input  logic [63:0]     counter,
    input  logic [5:0]      rd_pos,
    output logic [7:0]      ks_byte
);

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_ROUND = 2'd1;
    localparam logic [1:0] CS_FINAL = 2'd2;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_TOTAL - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       words_reg  [16];
    logic [31:0]       words_next [16];
    logic [31:0]       init_w     [16];
    logic [31:0]       rd_word;

    always_comb
    begin
        init_w[0] = SIGMA_0;
        init_w[1] = SIGMA_1;
        init_w[2] = SIGMA_2;
        init_w[3] = SIGMA_3;
        for (int k = 0; k < KEY_REGS; k++)
        begin
            init_w[4 + 2 * k] = key_words[k][31:0];
            init_w[5 + 2 * k] = key_words[k][63:32];
        end
        init_w[12] = counter[31:0];
        init_w[13] = counter[63:32];
        init_w[14] = nonce[31:0];
        init_w[15] = nonce[63:32];
    end

    always_comb
    begin
        logic              diag;
        logic [1:0]        sub;
        logic [1:0]        ln;
        logic [3:0]        ia, ib, ic, id, ix, iy, iz;
        logic [31:0]       sum, mix, rot;

        state_next = state_reg;
        step_next  = step_reg;
        words_next = words_reg;
        diag = step_reg[2];
        sub  = step_reg[1:0];
        ln   = '0;
        ia   = '0;
        ib   = '0;
        ic   = '0;
        id   = '0;
        ix   = '0;
        iy   = '0;
        iz   = '0;
        sum  = '0;
        mix  = '0;
        rot  = '0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (ctl.start)
                begin
                    words_next = init_w;
                    step_next  = '0;
                    state_next = CS_ROUND;
                end
            end
            CS_ROUND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ln = 2'(i);
                    ia = {2'b00, ln};
                    ib = {2'b01, ln + {1'b0, diag}};
                    ic = {2'b10, ln + {diag, 1'b0}};
                    id = {2'b11, ln + {diag, diag}};
                    if (sub[0])
                    begin
                        ix = ic; iy = id; iz = ib;
                    end
                    else
                    begin
                        ix = ia; iy = ib; iz = id;
                    end
                    sum = words_reg[ix] + words_reg[iy];
                    mix = words_reg[iz] ^ sum;
                    unique case (sub)
                        2'd0:    rot = {mix[15:0], mix[31:16]};
                        2'd1:    rot = {mix[19:0], mix[31:20]};
                        2'd2:    rot = {mix[23:0], mix[31:24]};
                        default: rot = {mix[24:0], mix[31:25]};
                    endcase
                    words_next[ix] = sum;
                    words_next[iz] = rot;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = CS_FINAL;
            end
            CS_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                    words_next[i] = words_reg[i] + init_w[i];
                state_next = CS_IDLE;
            end
            default:
                state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    assign rd_word   = words_reg[rd_pos[5:2]];
    assign ks_byte   = 8'(rd_word >> {rd_pos[1:0], 3'b000});
    assign stat.busy = (state_reg != CS_IDLE);
    assign stat.done = (state_reg == CS_FINAL);

endmodule

// File: hdl/chacha8_stream_cipher_unit.sv
// ChaCha8 byte stream cipher, top level.
// Depends on cc8_pkg, cc8_if, cc8_core and the assertion macro header.
//
// Usage: bytes enter on msg_in (valid/ready, data_byte, last_byte); each beat
// yields one beat on msg_out carrying data_byte XOR the keystream byte and a
// copy of last_byte. Key and nonce are written through cfg_wr_en, cfg_index,
// cfg_data (index 0-3 key words, 4 nonce; other indexes ignored); the user
// must write them only while idle, as the block does not enforce it. A byte
// that is not the first of a 64-byte block shows on msg_out in the cycle
// after its beat. The first byte of a block waits for the block core (start,
// add/xor/rotate steps for all rounds, final add) and then the emit state.
// Bytes inside a block are taken one per cycle while msg_out does not stall;
// the core does one add/xor/rotate across four lanes per cycle.
// After a last_byte beat the position and counter restart at zero.
// Reset clears key, nonce, counter and position. When msg_out stalls the
// result is held and msg_in stays not ready until that beat is taken or the
// output register frees in the same cycle.
`include "chacha8_stream_cipher_unit_defines.svh"

module chacha8_stream_cipher_unit
    import cc8_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cc8_in_if.sink               msg_in,
    cc8_out_if.source            msg_out,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    cfg_word_t   key_reg [KEY_REGS];
    cfg_word_t   nonce_reg;
    logic [63:0] counter_reg, counter_next;
    logic [5:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        accept, out_free;
    logic [7:0]  ks_byte;
    cc8_ctl_t    core_ctl;
    cc8_stat_t   core_stat;

    cc8_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (core_ctl),
        .stat      (core_stat),
        .key_words (key_reg),
        .nonce     (nonce_reg),
        .counter   (counter_reg),
        .rd_pos    (pos_reg),
        .ks_byte   (ks_byte)
    );

    assign out_free     = !out_valid_reg || msg_out.ready;
    assign msg_in.ready = (state_reg == ST_IDLE) && out_free;
    assign accept       = msg_in.valid && msg_in.ready;

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !msg_out.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        core_ctl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = msg_in.data_byte;
                    last_next = msg_in.last_byte;
                    if (pos_reg == '0)
                    begin
                        core_ctl.start = 1'b1;
                        state_next     = ST_GEN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = msg_in.data_byte ^ ks_byte;
                        out_last_next  = msg_in.last_byte;
                        if (msg_in.last_byte)
                        begin
                            pos_next     = '0;
                            counter_next = '0;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_GEN:
            begin
                if (core_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    out_last_next  = last_reg;
                    if (last_reg)
                    begin
                        pos_next     = '0;
                        counter_next = '0;
                    end
                    else
                    begin
                        pos_next     = 6'd1;
                        counter_next = counter_reg + 64'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            nonce_reg     <= '0;
            for (int k = 0; k < KEY_REGS; k++)
                key_reg[k] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_KEY_01: key_reg[0] <= cfg_data;
                    CFG_KEY_23: key_reg[1] <= cfg_data;
                    CFG_KEY_45: key_reg[2] <= cfg_data;
                    CFG_KEY_67: key_reg[3] <= cfg_data;
                    CFG_NONCE:  nonce_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    assign msg_out.valid       = out_valid_reg;
    assign msg_out.result_byte = out_byte_reg;
    assign msg_out.result_last = out_last_reg;

    `CC8_ASSERT_IMP(a_start_idle, clk, rst_n, core_ctl.start, !core_stat.busy, "core start while busy")
    `CC8_ASSERT_IMP(a_gen_pos0, clk, rst_n, state_reg != ST_IDLE, pos_reg == '0, "block generation off boundary")
    `CC8_ASSERT_NEXT(a_mid_emit, clk, rst_n, accept && (pos_reg != '0), out_valid_reg && (state_reg == ST_IDLE), "mid-block byte not emitted")
    `CC8_ASSERT_IMP(a_busy_gen, clk, rst_n, core_stat.busy, state_reg == ST_GEN, "core busy outside generation")

endmodule

// File: dv/tb_chacha8_stream_cipher_unit.sv
// Self-checking testbench for chacha8_stream_cipher_unit: directed and random byte messages
// across several key/nonce settings, checked against an in-bench ChaCha keystream predictor.
// Depends on cc8_pkg, cc8_if and the cipher RTL.
module tb_chacha8_stream_cipher_unit;
    import cc8_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 155;
    localparam int NUM_PHASES     = 7;
    localparam int CFG_REGS       = 5;
    localparam int STALL_PCT      = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } cipher_beat_t;

    typedef struct packed {
        bit         pinned;
        logic [7:0] value;
    } pinned_byte_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        bit         pinned;
        logic [7:0] value;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cc8_in_if  in_ch();
    cc8_out_if out_ch();

    chacha8_stream_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (in_ch),
        .msg_out   (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // keystream predictor state
    cfg_word_t   cfg_shadow [CFG_REGS];
    logic [63:0] blk_count;
    logic [5:0]  ks_pos;
    logic [31:0] ks_words [16];
    logic [31:0] mix_w [16];

    cipher_beat_t cipher_q [$];
    pinned_byte_t pinned_q [$];
    int  errors;
    int  idle_cycles;
    bit  stall_en;

    // zero key, zero nonce, block 0: first keystream bytes for eight rounds
    directed_row_t directed_rows [] = '{
        '{8'h00, 1'b0, 1'b1, 8'h3e},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'hef},
        '{8'h00, 1'b0, 1'b1, 8'h2f},
        '{8'hff, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b0, 8'h00},
        '{8'haa, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b1, 8'h3e},
        '{8'h00, 1'b0, 1'b1, 8'h3e},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h00, 1'b1, 1'b1, 8'hef},
        '{8'hff, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'h3e}
    };

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_round(input int a, input int b, input int c, input int d);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
    endfunction

    function automatic void refill_keystream();
        logic [31:0] seed [16];
        seed[0] = SIGMA_0;
        seed[1] = SIGMA_1;
        seed[2] = SIGMA_2;
        seed[3] = SIGMA_3;
        for (int i = 0; i < KEY_REGS; i++)
        begin
            seed[4 + 2 * i] = cfg_shadow[i][31:0];
            seed[5 + 2 * i] = cfg_shadow[i][63:32];
        end
        seed[12] = blk_count[31:0];
        seed[13] = blk_count[63:32];
        seed[14] = cfg_shadow[CFG_NONCE][31:0];
        seed[15] = cfg_shadow[CFG_NONCE][63:32];
        mix_w = seed;
        for (int r = 0; r < ROUND_COUNT; r += 2)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_words[i] = mix_w[i] + seed[i];
    endfunction

    function automatic logic [7:0] next_keystream_byte(input logic last);
        logic [31:0] word;
        if (ks_pos == 6'd0)
        begin
            refill_keystream();
            blk_count = blk_count + 64'd1;
        end
        word = ks_words[ks_pos[5:2]] >> (8 * ks_pos[1:0]);
        if (last)
        begin
            ks_pos    = 6'd0;
            blk_count = 64'd0;
        end
        else
        begin
            ks_pos = ks_pos + 6'd1;
        end
        return word[7:0];
    endfunction

    task automatic note_error(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: random backpressure while stall_en is set
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !stall_en || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // prediction, checking and watchdog
    always @(posedge clk)
    begin
        cipher_beat_t want;
        pinned_byte_t pin;
        logic [7:0]   ks;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_ch.valid && in_ch.ready)
            begin
                idle_cycles = 0;
                pin = pinned_q.pop_front();
                ks = next_keystream_byte(in_ch.last_byte);
                want.text = pin.pinned ? pin.value : (in_ch.data_byte ^ ks);
                want.last = in_ch.last_byte;
                cipher_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                idle_cycles = 0;
                if (cipher_q.size() == 0)
                begin
                    note_error($sformatf("unexpected beat result_byte=%h result_last=%b",
                                         out_ch.result_byte, out_ch.result_last));
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_ch.result_byte !== want.text)
                        note_error($sformatf("result_byte expected %h actual %h",
                                             want.text, out_ch.result_byte));
                    if (out_ch.result_last !== want.last)
                        note_error($sformatf("result_last expected %b actual %b",
                                             want.last, out_ch.result_last));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_chacha8_stream_cipher_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] text, input logic last, input bit pinned,
                             input logic [7:0] value);
        pinned_byte_t pin;
        while (stall_en && $urandom_range(99) < STALL_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pin.pinned = pinned;
        pin.value  = value;
        pinned_q.push_back(pin);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= text;
        in_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // hold input off until every result is back, then let the core settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx <= CFG_NONCE)
            cfg_shadow[idx] = val;
    endtask

    task automatic send_messages(input int items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                len = $urandom_range(1, 16);
            else if (pick < 65)
                len = 64 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
            else if (pick < 88)
                len = $urandom_range(17, 80);
            else
                len = $urandom_range(81, 200);
            // a message cut short by the budget stays open into the next setting
            for (int k = 0; k < len && sent < items; k++)
            begin
                push_byte(8'($urandom_range(255)), k == len - 1, 1'b0, 8'h00);
                sent++;
            end
        end
    endtask

    initial
    begin
        cfg_word_t vals [CFG_REGS];
        logic [CFG_IDX_W-1:0] reg_idx [CFG_REGS];
        reg_idx = '{CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67, CFG_NONCE};
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors      = 0;
        idle_cycles = 0;
        stall_en    = 1'b1;
        for (int i = 0; i < CFG_REGS; i++)
            cfg_shadow[i] = '0;
        blk_count = 64'd0;
        ks_pos    = 6'd0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_byte(directed_rows[i].text, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].value);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            for (int i = 0; i < CFG_REGS; i++)
            begin
                case (p)
                    0: vals[i] = '1;
                    2: vals[i] = (reg_idx[i] == CFG_NONCE) ? '1 : '0;
                    5: vals[i] = i[0] ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
                    6: vals[i] = '0;
                    default: vals[i] = {$urandom, $urandom};
                endcase
            end
            if (p == 4)
            begin
                cfg_write(CFG_KEY_23, vals[1]);
                cfg_write(CFG_NONCE, vals[4]);
            end
            else
            begin
                foreach (reg_idx[i])
                    cfg_write(reg_idx[i], vals[i]);
            end
            // writes to unused indexes must leave key and nonce alone
            if (p == 0 || p == 6)
                cfg_write(CFG_SPARE_LO, '1);
            if (p == 1)
                cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
            cfg_wr_en <= 1'b0;
            stall_en = (p != 3);
            send_messages(PHASE_ITEMS);
        end

        stall_en = 1'b1;
        in_ch.valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (cipher_q.size() != 0)
            note_error($sformatf("%0d results never arrived", cipher_q.size()));

        if (errors == 0)
            $display("tb_chacha8_stream_cipher_unit: PASS");
        else
            $display("tb_chacha8_stream_cipher_unit: FAIL");
        $finish;
    end
endmodule
